// File: rtl/pst_pkg.sv
// shared types and constants for the priority task scheduler
package pst_pkg;

    localparam int DEF_TASK_SLOTS = 16;
    localparam int DEF_SEM_SLOTS  = 8;

    localparam logic [7:0]  LOWEST_PRIO_RST = 8'hFF;
    localparam logic [15:0] SEM_COUNT_MAX   = 16'hFFFF;

    typedef enum logic [3:0] {
        OP_CREATE    = 4'd0,
        OP_DISPATCH  = 4'd1,
        OP_YIELD     = 4'd2,
        OP_DELAY     = 4'd3,
        OP_TERMINATE = 4'd4,
        OP_TICK      = 4'd5,
        OP_SEM_INIT  = 4'd6,
        OP_SEM_WAIT  = 4'd7,
        OP_SEM_POST  = 4'd8
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NONE_READY  = 3'd1,
        ST_TABLE_FULL  = 3'd2,
        ST_BAD_PRIO    = 3'd3,
        ST_NO_RUNNING  = 3'd4,
        ST_BLOCKED     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DISP,
        S_POST,
        S_INS_RD,
        S_INS_CMP,
        S_TICK_RD,
        S_TICK_EV,
        S_TICK_NX
    } t_state;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  priority_req;
        logic [31:0] sleep_ticks;
        logic [2:0]  sem_index;
        logic [15:0] init_value;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] task_id;
        logic [4:0] woken_count;
    } t_rsp;

endpackage

// File: rtl/pst_ram.sv
// generic single write port ram with registered read
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/priority_task_scheduler.sv
// fixed priority task scheduler with counting semaphores, top level
//
// channel   direction  signals                      handshake
// request   in         i_req (pst_pkg::t_req)       start && !busy
// result    out        o_rsp (pst_pkg::t_rsp)       o_valid, one cycle pulse
// config    in         i_cfg_wdata (lowest prio)    i_cfg_we
//
// a request that touches no list passes through exec only; dispatch and a
// releasing post add a state; a ready list insert adds a read, and a compare
// when it stops behind an entry, plus a read and a compare per entry walked past
// a tick reads, ages and steps past every sleeper, plus one insert per woken task while the ready list has room
// busy is high while a request is in flight and falls as the result is strobed
// synchronous active low reset; list memories need no clearing
// the result is shown for one cycle and cannot be held off
module priority_task_scheduler #(
    parameter int TASK_SLOTS = pst_pkg::DEF_TASK_SLOTS,
    parameter int SEM_SLOTS  = pst_pkg::DEF_SEM_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pst_pkg::t_req i_req,
    output logic          o_valid,
    output pst_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);

    localparam int IDW = $clog2(TASK_SLOTS);
    localparam int CW  = $clog2(TASK_SLOTS + 1);
    localparam int SW  = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
    localparam int SXW = ($clog2(SEM_SLOTS + 1) > 3) ? $clog2(SEM_SLOTS + 1) : 3;
    localparam int WAW = $clog2(SEM_SLOTS * TASK_SLOTS);
    localparam int RW  = IDW + 8;
    localparam int SLW = IDW + 8 + 32;

    function automatic logic [IDW-1:0] add_mod(input logic [IDW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [IDW:0] s;
        s = (IDW+1)'(a) + (IDW+1)'(b);
        if (s >= (IDW+1)'(TASK_SLOTS)) begin
            s = s - (IDW+1)'(TASK_SLOTS);
        end
        return s[IDW-1:0];
    endfunction

    function automatic logic [IDW-1:0] inc_mod(input logic [IDW-1:0] a);
        return (a == IDW'(TASK_SLOTS - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [IDW-1:0] dec_mod(input logic [IDW-1:0] a);
        return (a == '0) ? IDW'(TASK_SLOTS - 1) : a - 1'b1;
    endfunction

    function automatic logic [WAW-1:0] wt_addr(input logic [SW-1:0] s,
                                               input logic [IDW-1:0] p);
        return WAW'(WAW'(s) * WAW'(TASK_SLOTS)) + WAW'(p);
    endfunction

    pst_pkg::t_state r_state, n_state;
    pst_pkg::t_req   r_req;
    pst_pkg::t_rsp   r_rsp, n_rsp;
    logic            r_valid;
    logic [7:0]      r_lowest;
    logic [CW-1:0]   r_created, n_created;
    logic [IDW-1:0]  r_run_id, n_run_id;
    logic [7:0]      r_run_prio, n_run_prio;
    logic            r_run_valid, n_run_valid;
    logic [IDW-1:0]  r_rdy_head, n_rdy_head;
    logic [CW-1:0]   r_rdy_len, n_rdy_len;
    logic [CW-1:0]   r_slp_len, n_slp_len;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic            r_in_tick, n_in_tick;
    logic [IDW-1:0]  r_ins_id, n_ins_id;
    logic [7:0]      r_ins_prio, n_ins_prio;
    logic [IDW-1:0]  r_ins_pos, n_ins_pos;
    logic [CW-1:0]   r_ins_cnt, n_ins_cnt;
    logic [15:0]     r_sem_cnt  [SEM_SLOTS];
    logic [15:0]     n_sem_cnt  [SEM_SLOTS];
    logic [IDW-1:0]  r_sem_head [SEM_SLOTS];
    logic [IDW-1:0]  n_sem_head [SEM_SLOTS];
    logic [CW-1:0]   r_sem_len  [SEM_SLOTS];
    logic [CW-1:0]   n_sem_len  [SEM_SLOTS];

    logic            rdy_we, slp_we, wt_we;
    logic [IDW-1:0]  rdy_waddr, rdy_raddr, slp_waddr, slp_raddr;
    logic [RW-1:0]   rdy_wdata, rdy_dout;
    logic [SLW-1:0]  slp_wdata, slp_dout;
    logic [WAW-1:0]  wt_waddr, wt_raddr;
    logic [RW-1:0]   wt_wdata, wt_dout;

    logic [SXW-1:0]  sem_ext;
    logic [SW-1:0]   sidx;
    logic            bad_sem, needs_run, run_missing, ins_can;
    logic            ins_gt, tick_last, wake;
    logic [31:0]     ev_rem;
    logic [IDW-1:0]  rdy_tail;
    pst_pkg::t_state ret_state;

    pst_ram #(.WIDTH(RW), .DEPTH(TASK_SLOTS)) u_rdy_ram (
        .i_clk(i_clk), .i_we(rdy_we), .i_waddr(rdy_waddr), .i_wdata(rdy_wdata),
        .i_raddr(rdy_raddr), .o_rdata(rdy_dout)
    );

    pst_ram #(.WIDTH(SLW), .DEPTH(TASK_SLOTS)) u_slp_ram (
        .i_clk(i_clk), .i_we(slp_we), .i_waddr(slp_waddr), .i_wdata(slp_wdata),
        .i_raddr(slp_raddr), .o_rdata(slp_dout)
    );

    pst_ram #(.WIDTH(RW), .DEPTH(SEM_SLOTS * TASK_SLOTS)) u_wt_ram (
        .i_clk(i_clk), .i_we(wt_we), .i_waddr(wt_waddr), .i_wdata(wt_wdata),
        .i_raddr(wt_raddr), .o_rdata(wt_dout)
    );

    assign sem_ext     = SXW'(r_req.sem_index);
    assign sidx        = sem_ext[SW-1:0];
    assign bad_sem     = (r_req.opcode == pst_pkg::OP_SEM_INIT ||
                          r_req.opcode == pst_pkg::OP_SEM_WAIT ||
                          r_req.opcode == pst_pkg::OP_SEM_POST) &&
                         (sem_ext >= SXW'(SEM_SLOTS));
    assign needs_run   = (r_req.opcode == pst_pkg::OP_YIELD ||
                          r_req.opcode == pst_pkg::OP_DELAY ||
                          r_req.opcode == pst_pkg::OP_TERMINATE ||
                          r_req.opcode == pst_pkg::OP_SEM_WAIT);
    assign run_missing = needs_run && !r_run_valid && !bad_sem;
    assign ins_can     = (r_rdy_len < CW'(TASK_SLOTS));
    assign rdy_tail    = add_mod(r_rdy_head, r_rdy_len);
    // entry ahead of the insert point is less urgent, so it moves back one
    assign ins_gt      = (rdy_dout[7:0] > r_ins_prio);
    assign ev_rem      = slp_dout[31:0] - 32'd1;
    assign wake        = (ev_rem == 32'd0);
    assign tick_last   = ((r_i + 1'b1) == r_slp_len);
    assign ret_state   = r_in_tick ? pst_pkg::S_TICK_NX : pst_pkg::S_IDLE;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pst_pkg::S_IDLE: begin
                if (start) begin
                    n_state = pst_pkg::S_EXEC;
                end
            end
            pst_pkg::S_EXEC: begin
                n_state = pst_pkg::S_IDLE;
                if (!run_missing && !bad_sem) begin
                    case (r_req.opcode)
                        pst_pkg::OP_CREATE: begin
                            if (r_req.priority_req <= r_lowest &&
                                r_created < CW'(TASK_SLOTS) && ins_can) begin
                                n_state = pst_pkg::S_INS_RD;
                            end
                        end
                        pst_pkg::OP_DISPATCH: begin
                            if (!r_run_valid && r_rdy_len != '0) begin
                                n_state = pst_pkg::S_DISP;
                            end
                        end
                        pst_pkg::OP_YIELD: begin
                            if (ins_can) begin
                                n_state = pst_pkg::S_INS_RD;
                            end
                        end
                        pst_pkg::OP_DELAY: begin
                            if (r_req.sleep_ticks == 32'd0 && ins_can) begin
                                n_state = pst_pkg::S_INS_RD;
                            end
                        end
                        pst_pkg::OP_TICK: begin
                            if (r_slp_len != '0) begin
                                n_state = pst_pkg::S_TICK_RD;
                            end
                        end
                        pst_pkg::OP_SEM_POST: begin
                            if (r_sem_len[sidx] != '0) begin
                                n_state = pst_pkg::S_POST;
                            end
                        end
                        default: begin
                            n_state = pst_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            pst_pkg::S_DISP: begin
                n_state = pst_pkg::S_IDLE;
            end
            pst_pkg::S_POST: begin
                n_state = ins_can ? pst_pkg::S_INS_RD : pst_pkg::S_IDLE;
            end
            pst_pkg::S_INS_RD: begin
                n_state = (r_ins_cnt == '0) ? ret_state : pst_pkg::S_INS_CMP;
            end
            pst_pkg::S_INS_CMP: begin
                n_state = ins_gt ? pst_pkg::S_INS_RD : ret_state;
            end
            pst_pkg::S_TICK_RD: begin
                n_state = pst_pkg::S_TICK_EV;
            end
            pst_pkg::S_TICK_EV: begin
                n_state = (wake && ins_can) ? pst_pkg::S_INS_RD : pst_pkg::S_TICK_NX;
            end
            pst_pkg::S_TICK_NX: begin
                n_state = tick_last ? pst_pkg::S_IDLE : pst_pkg::S_TICK_RD;
            end
            default: begin
                n_state = pst_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_rsp       = r_rsp;
        n_created   = r_created;
        n_run_id    = r_run_id;
        n_run_prio  = r_run_prio;
        n_run_valid = r_run_valid;
        n_rdy_head  = r_rdy_head;
        n_rdy_len   = r_rdy_len;
        n_slp_len   = r_slp_len;
        n_i         = r_i;
        n_j         = r_j;
        n_in_tick   = r_in_tick;
        n_ins_id    = r_ins_id;
        n_ins_prio  = r_ins_prio;
        n_ins_pos   = r_ins_pos;
        n_ins_cnt   = r_ins_cnt;
        n_sem_cnt   = r_sem_cnt;
        n_sem_head  = r_sem_head;
        n_sem_len   = r_sem_len;
        rdy_we      = 1'b0;
        rdy_waddr   = r_ins_pos;
        rdy_wdata   = {r_ins_id, r_ins_prio};
        rdy_raddr   = r_rdy_head;
        slp_we      = 1'b0;
        slp_waddr   = r_slp_len[IDW-1:0];
        slp_wdata   = {r_run_id, r_run_prio, r_req.sleep_ticks};
        slp_raddr   = r_i[IDW-1:0];
        wt_we       = 1'b0;
        wt_waddr    = wt_addr(sidx, add_mod(r_sem_head[sidx], r_sem_len[sidx]));
        wt_wdata    = {r_run_id, r_run_prio};
        wt_raddr    = wt_addr(sidx, r_sem_head[sidx]);

        case (r_state)
            pst_pkg::S_EXEC: begin
                n_rsp     = '{status: pst_pkg::ST_OK, task_id: '0, woken_count: '0};
                n_in_tick = 1'b0;
                n_ins_pos = rdy_tail;
                n_ins_cnt = r_rdy_len;
                n_ins_id  = r_run_id;
                n_ins_prio = r_run_prio;
                if (run_missing) begin
                    n_rsp.status = pst_pkg::ST_NO_RUNNING;
                end else if (!bad_sem) begin
                    case (r_req.opcode)
                        pst_pkg::OP_CREATE: begin
                            if (r_req.priority_req > r_lowest) begin
                                n_rsp.status = pst_pkg::ST_BAD_PRIO;
                            end else if (r_created >= CW'(TASK_SLOTS)) begin
                                n_rsp.status = pst_pkg::ST_TABLE_FULL;
                            end else begin
                                n_rsp.task_id = 4'(r_created);
                                n_created     = r_created + 1'b1;
                                n_ins_id      = r_created[IDW-1:0];
                                n_ins_prio    = r_req.priority_req;
                            end
                        end
                        pst_pkg::OP_DISPATCH: begin
                            if (r_run_valid) begin
                                n_rsp.task_id = 4'(r_run_id);
                            end else if (r_rdy_len == '0) begin
                                n_rsp.status = pst_pkg::ST_NONE_READY;
                            end
                        end
                        pst_pkg::OP_YIELD: begin
                            n_run_valid = 1'b0;
                        end
                        pst_pkg::OP_DELAY: begin
                            if (r_req.sleep_ticks == 32'd0) begin
                                n_run_valid = 1'b0;
                            end else if (r_slp_len < CW'(TASK_SLOTS)) begin
                                slp_we      = 1'b1;
                                n_slp_len   = r_slp_len + 1'b1;
                                n_run_valid = 1'b0;
                            end
                        end
                        pst_pkg::OP_TERMINATE: begin
                            n_run_valid = 1'b0;
                        end
                        pst_pkg::OP_TICK: begin
                            n_in_tick = 1'b1;
                            n_i       = '0;
                            n_j       = '0;
                        end
                        pst_pkg::OP_SEM_INIT: begin
                            n_sem_cnt[sidx] = r_req.init_value;
                            n_sem_len[sidx] = '0;
                        end
                        pst_pkg::OP_SEM_WAIT: begin
                            if (r_sem_cnt[sidx] != 16'd0) begin
                                n_sem_cnt[sidx] = r_sem_cnt[sidx] - 16'd1;
                            end else if (r_sem_len[sidx] < CW'(TASK_SLOTS)) begin
                                wt_we           = 1'b1;
                                n_sem_len[sidx] = r_sem_len[sidx] + 1'b1;
                                n_run_valid     = 1'b0;
                                n_rsp.status    = pst_pkg::ST_BLOCKED;
                            end
                        end
                        pst_pkg::OP_SEM_POST: begin
                            if (r_sem_len[sidx] == '0 &&
                                r_sem_cnt[sidx] != pst_pkg::SEM_COUNT_MAX) begin
                                n_sem_cnt[sidx] = r_sem_cnt[sidx] + 16'd1;
                            end
                        end
                        default: begin
                            n_rsp.status = pst_pkg::ST_OK;
                        end
                    endcase
                end
            end
            pst_pkg::S_DISP: begin
                n_run_id      = rdy_dout[RW-1 -: IDW];
                n_run_prio    = rdy_dout[7:0];
                n_run_valid   = 1'b1;
                n_rdy_head    = inc_mod(r_rdy_head);
                n_rdy_len     = r_rdy_len - 1'b1;
                n_rsp.task_id = 4'(rdy_dout[RW-1 -: IDW]);
            end
            pst_pkg::S_POST: begin
                n_sem_head[sidx]  = inc_mod(r_sem_head[sidx]);
                n_sem_len[sidx]   = r_sem_len[sidx] - 1'b1;
                n_rsp.task_id     = 4'(wt_dout[RW-1 -: IDW]);
                n_rsp.woken_count = 5'd1;
                n_ins_id          = wt_dout[RW-1 -: IDW];
                n_ins_prio        = wt_dout[7:0];
                n_ins_pos         = rdy_tail;
                n_ins_cnt         = r_rdy_len;
            end
            pst_pkg::S_INS_RD: begin
                rdy_raddr = dec_mod(r_ins_pos);
                if (r_ins_cnt == '0) begin
                    rdy_we    = 1'b1;
                    n_rdy_len = r_rdy_len + 1'b1;
                end
            end
            pst_pkg::S_INS_CMP: begin
                rdy_we = 1'b1;
                if (ins_gt) begin
                    rdy_wdata = rdy_dout;
                    n_ins_pos = dec_mod(r_ins_pos);
                    n_ins_cnt = r_ins_cnt - 1'b1;
                end else begin
                    n_rdy_len = r_rdy_len + 1'b1;
                end
            end
            pst_pkg::S_TICK_EV: begin
                if (wake) begin
                    n_rsp.woken_count = r_rsp.woken_count + 5'd1;
                    n_ins_id          = slp_dout[SLW-1 -: IDW];
                    n_ins_prio        = slp_dout[39:32];
                    n_ins_pos         = rdy_tail;
                    n_ins_cnt         = r_rdy_len;
                end else begin
                    // survivor is compacted toward the front of the sleep list
                    slp_we    = 1'b1;
                    slp_waddr = r_j[IDW-1:0];
                    slp_wdata = {slp_dout[SLW-1:32], ev_rem};
                    n_j       = r_j + 1'b1;
                end
            end
            pst_pkg::S_TICK_NX: begin
                n_i = r_i + 1'b1;
                if (tick_last) begin
                    n_slp_len = r_j;
                end
            end
            default: begin
                n_rsp = r_rsp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pst_pkg::S_IDLE;
            r_valid     <= 1'b0;
            r_lowest    <= pst_pkg::LOWEST_PRIO_RST;
            r_created   <= '0;
            r_run_id    <= '0;
            r_run_valid <= 1'b0;
            r_rdy_head  <= '0;
            r_rdy_len   <= '0;
            r_slp_len   <= '0;
            r_in_tick   <= 1'b0;
            for (int k = 0; k < SEM_SLOTS; k++) begin
                r_sem_cnt[k]  <= '0;
                r_sem_head[k] <= '0;
                r_sem_len[k]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_valid     <= (n_state == pst_pkg::S_IDLE) && (r_state != pst_pkg::S_IDLE);
            if (i_cfg_we) begin
                r_lowest <= i_cfg_wdata;
            end
            r_created   <= n_created;
            r_run_id    <= n_run_id;
            r_run_valid <= n_run_valid;
            r_rdy_head  <= n_rdy_head;
            r_rdy_len   <= n_rdy_len;
            r_slp_len   <= n_slp_len;
            r_in_tick   <= n_in_tick;
            r_sem_cnt   <= n_sem_cnt;
            r_sem_head  <= n_sem_head;
            r_sem_len   <= n_sem_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_rsp      <= n_rsp;
        r_run_prio <= n_run_prio;
        r_i        <= n_i;
        r_j        <= n_j;
        r_ins_id   <= n_ins_id;
        r_ins_prio <= n_ins_prio;
        r_ins_pos  <= n_ins_pos;
        r_ins_cnt  <= n_ins_cnt;
    end

    assign busy    = (r_state != pst_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in flight");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted request did not start");

    a_cmp_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pst_pkg::S_INS_CMP |-> $past(r_state) == pst_pkg::S_INS_RD)
        else $error("insert compare without a read");

    a_run_from_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_run_valid) |-> $past(r_state) == pst_pkg::S_DISP)
        else $error("running task set outside dispatch");

endmodule
